// File: hw/rtl/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg: shared types and constants for the frame derandomiser
// LFSR step functions, register indices and reset values.
// ----------------------------------------------------------------------------
package fdr_pkg;

	localparam int LFSR_W  = 15;
	localparam int SKIP_W  = 16;
	localparam int FLEN_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// register indices on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd2;

	localparam logic [LFSR_W-1:0] SEED_RST      = 15'b011001110011111;
	localparam logic [SKIP_W-1:0] SKIP_RST      = 16'd10000;
	localparam logic [FLEN_W-1:0] FRAME_LEN_RST = 16'd44356;

	typedef struct packed {
		logic [BYTE_W-1:0] key;
		logic [LFSR_W-1:0] next;
	} lfsr_byte_t;

	typedef struct packed {
		logic              busy;
		logic [LFSR_W-1:0] start_state;
	} skip_stat_t;

	// one generator step: feedback bit14 ^ bit13 shifted in at bit 0
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
		logic b;
		b = s[14] ^ s[13];
		return {s[13:0], b};
	endfunction

	// eight steps, first emitted bit lands in the key MSB
	function automatic lfsr_byte_t lfsr_byte(input logic [LFSR_W-1:0] s);
		lfsr_byte_t r;
		logic [LFSR_W-1:0] st;
		logic [BYTE_W-1:0] k;
		logic b;
		st = s;
		k = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			b  = st[14] ^ st[13];
			k  = {k[BYTE_W-2:0], b};
			st = {st[13:0], b};
		end
		r.key  = k;
		r.next = st;
		return r;
	endfunction

endpackage

// File: hw/rtl/fdr_skip.sv
// ----------------------------------------------------------------------------
// fdr_skip: start-state sequencer
// Loads the seed and runs the generator skip_bits steps, eight per cycle
// while eight or more remain, then one per cycle.
// ----------------------------------------------------------------------------
module fdr_skip (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fdr_pkg::LFSR_W-1:0]   seed,
	input  logic [fdr_pkg::SKIP_W-1:0]   skip_bits,
	output fdr_pkg::skip_stat_t          stat
);

	logic [fdr_pkg::LFSR_W-1:0] state_q;
	logic [fdr_pkg::SKIP_W-1:0] remain_q;
	fdr_pkg::lfsr_byte_t        step8;

	assign step8 = fdr_pkg::lfsr_byte(state_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fdr_pkg::SEED_RST;
			remain_q <= fdr_pkg::SKIP_RST;
		end else if (start) begin
			state_q  <= seed;
			remain_q <= skip_bits;
		end else if (remain_q >= fdr_pkg::SKIP_W'(8)) begin
			state_q  <= step8.next;
			remain_q <= remain_q - fdr_pkg::SKIP_W'(8);
		end else if (remain_q != '0) begin
			state_q  <= fdr_pkg::lfsr_step(state_q);
			remain_q <= remain_q - fdr_pkg::SKIP_W'(1);
		end
	end

	assign stat.busy        = (remain_q != '0);
	assign stat.start_state = state_q;

endmodule

// File: hw/rtl/lfsr_frame_derandomizer_top.sv
// ----------------------------------------------------------------------------
// lfsr_frame_derandomizer_top: additive x^15+x^14+1 frame descrambler
// One byte per beat is XORed with eight generator bits, MSB first; odd frame
// positions are inverted and the last byte of a frame is marked with tlast.
// ----------------------------------------------------------------------------
// Each input beat is registered, leaving in the cycle after it is taken; one
//   byte per cycle when not stalled, set by the eight-step generator update.
// Reset (arst_n low, asynchronous): configuration and control registers take
//   their reset values and the start state is rebuilt, with s_tready low until
//   it is loaded. The same pause follows every write to a defined register.
module lfsr_frame_derandomizer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_in
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // [7:0] data_out
	output logic                             m_tlast,   // frame_end
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fdr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fdr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// configuration registers
	logic [fdr_pkg::LFSR_W-1:0] seed_q;
	logic [fdr_pkg::SKIP_W-1:0] skip_bits_q;
	logic [fdr_pkg::FLEN_W-1:0] frame_length_q;

	// restart control: restart_q kicks the skip sequencer, load_q holds the
	// input off until the generator has been loaded with the new start state
	logic restart_q;
	logic load_q;

	// running state
	logic [fdr_pkg::LFSR_W-1:0] gen_q;
	logic [fdr_pkg::FLEN_W-1:0] pos_q;

	fdr_pkg::skip_stat_t  stat;
	fdr_pkg::lfsr_byte_t  kb;
	logic                 cfg_we;
	logic                 cfg_hit;
	logic                 in_beat;
	logic                 last;
	logic [fdr_pkg::FLEN_W-1:0] pos_inc;
	logic [7:0]           data_x;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_we && ((cfg_index == fdr_pkg::REG_SEED) ||
	                              (cfg_index == fdr_pkg::REG_SKIP_BITS) ||
	                              (cfg_index == fdr_pkg::REG_FRAME_LEN));

	// input taken whenever no restart is pending and the output register is free or being drained
	assign s_tready = !load_q && (!m_tvalid || m_tready);
	assign in_beat  = s_tvalid && s_tready;

	// per-byte datapath
	assign kb      = fdr_pkg::lfsr_byte(gen_q);
	assign pos_inc = pos_q + fdr_pkg::FLEN_W'(1);
	// frame_length of zero wraps to a 65536-byte frame
	assign last    = (pos_inc == frame_length_q);
	assign data_x  = (s_tdata ^ kb.key) ^ {8{pos_q[0]}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q         <= fdr_pkg::SEED_RST;
			skip_bits_q    <= fdr_pkg::SKIP_RST;
			frame_length_q <= fdr_pkg::FRAME_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fdr_pkg::REG_SEED:      seed_q         <= cfg_data[fdr_pkg::LFSR_W-1:0];
				fdr_pkg::REG_SKIP_BITS: skip_bits_q    <= cfg_data;
				fdr_pkg::REG_FRAME_LEN: frame_length_q <= cfg_data;
				default: ; // unknown index: ignored
			endcase
		end
	end

	fdr_skip u_skip (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (restart_q),
		.seed      (seed_q),
		.skip_bits (skip_bits_q),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b0;
			load_q    <= 1'b1;
		end else begin
			restart_q <= cfg_hit;
			if (cfg_hit) begin
				load_q <= 1'b1;
			end else if (load_q && !restart_q && !stat.busy) begin
				load_q <= 1'b0;
			end
		end
	end

	// generator and position: reloaded at the end of a restart and after the
	// last byte of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
			pos_q <= '0;
		end else if (load_q) begin
			gen_q <= stat.start_state;
			pos_q <= '0;
		end else if (in_beat) begin
			if (last) begin
				gen_q <= stat.start_state;
				pos_q <= '0;
			end else begin
				gen_q <= kb.next;
				pos_q <= pos_inc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_beat) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			m_tdata <= data_x;
			m_tlast <= last;
		end
	end

	// position never runs past the frame once the generator is loaded
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!load_q && frame_length_q != '0) |-> (pos_q < frame_length_q))
		else $error("frame position beyond frame length");

	// an input beat at the last position yields a flagged output beat
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && last) |=> (m_tvalid && m_tlast))
		else $error("frame end not flagged");

	// after a frame end the generator restarts from the start state
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && last && !cfg_hit) |=>
		(pos_q == '0 && gen_q == $past(stat.start_state)))
		else $error("generator not reloaded at frame end");

	// no beat is taken while a restart is pending
	a_no_beat_in_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(restart_q || stat.busy) |-> !s_tready)
		else $error("input accepted during restart");

endmodule

// File: bench/tb_lfsr_frame_derandomizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lfsr_frame_derandomizer_top: self-checking bench for the frame descrambler
// Streams bytes and register writes into the block, predicts each output beat
// with a behavioural 15-bit generator and compares data and frame end in order.
// ----------------------------------------------------------------------------
module tb_lfsr_frame_derandomizer_top;

	// index 3 exists on the bus but maps to no register
	localparam logic [fdr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [fdr_pkg::BYTE_W-1:0] data;
		logic                       last;
	} plain_beat_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = '0;   // [7:0] data_in
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [7:0]                     m_tdata;          // [7:0] data_out
	logic                           m_tlast;          // frame_end
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [fdr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fdr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of the registers and generator state
	logic [fdr_pkg::LFSR_W-1:0] seed_reg;
	logic [fdr_pkg::SKIP_W-1:0] skip_reg;
	logic [fdr_pkg::FLEN_W-1:0] flen_reg;
	logic [fdr_pkg::LFSR_W-1:0] key_start;
	logic [fdr_pkg::LFSR_W-1:0] key_gen;
	logic [fdr_pkg::FLEN_W-1:0] frame_pos;

	plain_beat_t plain_q[$];   // descrambled beats still owed by the block
	int errors         = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_cycles    = 0;    // long m_tready hold-off, counted down by the sink

	lfsr_frame_derandomizer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run the seed forward skip_bits steps; frame restarts from here.
	function automatic void rebuild_start_state();
		logic [fdr_pkg::LFSR_W-1:0] s;
		int n;
		s = seed_reg;
		for (n = 0; n < skip_reg; n++)
			s = {s[fdr_pkg::LFSR_W-2:0], s[14] ^ s[13]};
		key_start = s;
		key_gen   = s;
		frame_pos = '0;
	endfunction

	// Any write to a real register restarts the generator; the spare index is dropped.
	function automatic void load_register(input logic [fdr_pkg::CFG_IDX_W-1:0] idx,
			input logic [fdr_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			fdr_pkg::REG_SEED:      seed_reg = val[fdr_pkg::LFSR_W-1:0];
			fdr_pkg::REG_SKIP_BITS: skip_reg = val;
			fdr_pkg::REG_FRAME_LEN: flen_reg = val;
			default:                return;
		endcase
		rebuild_start_state();
	endfunction

	// Eight generator steps give the key, first bit out in the MSB.
	// Odd frame positions are inverted; frame end reloads the start state.
	function automatic plain_beat_t descramble_byte(input logic [7:0] din);
		plain_beat_t r;
		logic [7:0] key;
		logic fb;
		int i;
		key = '0;
		for (i = 0; i < 8; i++) begin
			fb      = key_gen[14] ^ key_gen[13];
			key     = {key[6:0], fb};
			key_gen = {key_gen[fdr_pkg::LFSR_W-2:0], fb};
		end
		r.data = din ^ key;
		if (frame_pos[0])
			r.data = ~r.data;
		// 16-bit compare: a frame length of zero ends on position 65535
		r.last = (frame_pos + 16'd1) == flen_reg;
		if (r.last) begin
			key_gen   = key_start;
			frame_pos = '0;
		end else begin
			frame_pos = frame_pos + 16'd1;
		end
		return r;
	endfunction

	// Offer one byte, with random gaps ahead of it; predict on acceptance.
	task automatic send_byte(input logic [7:0] b);
		plain_beat_t p;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		p = descramble_byte(b);
		plain_q = {plain_q, p};
	endtask

	// Stop offering and let every owed beat come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (plain_q.size() != 0);
	endtask

	// Register write, only once the stream is idle.
	task automatic write_reg(input logic [fdr_pkg::CFG_IDX_W-1:0] idx,
			input logic [fdr_pkg::CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		load_register(idx, val);
		cfg_valid <= 1'b0;
	endtask

	// Sink: checks each accepted beat against the oldest prediction, then
	// picks m_tready for the next cycle (long hold-off takes priority).
	always @(posedge clk) begin
		plain_beat_t want;
		if (m_tvalid && m_tready) begin
			if (plain_q.size() == 0) begin
				errors++;
				$display("%0t: stray beat, expected none, actual data %02h last %0b",
					$time, m_tdata, m_tlast);
			end else begin
				want = plain_q.pop_front();
				if (m_tdata !== want.data) begin
					errors++;
					$display("%0t: data_out expected %02h, actual %02h",
						$time, want.data, m_tdata);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: frame_end expected %0b, actual %0b",
						$time, want.last, m_tlast);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Reset register values, data byte extremes.
	task automatic test_reset_defaults();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);
	endtask

	// All-zero seed never leaves zero: only the odd-position inversion remains.
	task automatic test_seed_zero();
		write_reg(fdr_pkg::REG_SEED, 16'h0000);
		send_byte(8'h00);
		send_byte(8'h5A);
		send_byte(8'hFF);
	endtask

	// Seed bit 15 dropped, skip extremes, spare index leaves the frame running.
	task automatic test_register_fields();
		write_reg(fdr_pkg::REG_SEED, 16'hFFFF);
		write_reg(fdr_pkg::REG_SKIP_BITS, 16'h0000);
		send_byte(8'h80);
		send_byte(8'h01);
		write_reg(fdr_pkg::REG_SKIP_BITS, 16'hFFFF);
		send_byte(8'hC3);
		send_byte(8'h3C);
		write_reg(fdr_pkg::REG_FRAME_LEN, 16'd3);
		send_byte(8'h12);
		send_byte(8'h34);
		write_reg(REG_SPARE, 16'hFFFF);
		send_byte(8'h56);
		send_byte(8'h78);
	endtask

	// Shortest frames: every beat last, then alternating.
	task automatic test_short_frames();
		write_reg(fdr_pkg::REG_SKIP_BITS, 16'd17);
		write_reg(fdr_pkg::REG_FRAME_LEN, 16'd1);
		repeat (3) send_byte(8'($urandom_range(255)));
		write_reg(fdr_pkg::REG_FRAME_LEN, 16'd2);
		repeat (4) send_byte(8'($urandom_range(255)));
	endtask

	// Random data in segments, each with fresh skip and frame length values and mostly a fresh seed.
	task automatic test_random_traffic(input int src_pct, input int sink_pct,
			input int n_items);
		int sent;
		int seg;
		int pick;
		logic [15:0] v;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		sent = 0;
		while (sent < n_items) begin
			// skip first, so a large old skip does not slow the other writes
			pick = $urandom_range(11);
			if (pick == 0)
				v = 16'hFFFF;
			else if (pick == 1)
				v = 16'($urandom_range(65535));
			else
				v = 16'($urandom_range(400));
			write_reg(fdr_pkg::REG_SKIP_BITS, v);
			// mostly short frames so that plenty of frame ends go by
			pick = $urandom_range(9);
			if (pick < 7)
				v = 16'($urandom_range(1, 24));
			else if (pick == 7)
				v = 16'($urandom_range(25, 400));
			else if (pick == 8)
				v = 16'hFFFF;
			else
				v = 16'h0000;
			write_reg(fdr_pkg::REG_FRAME_LEN, v);
			pick = $urandom_range(7);
			if (pick == 0)
				write_reg(fdr_pkg::REG_SEED, 16'h0000);
			else if (pick < 6)
				write_reg(fdr_pkg::REG_SEED, 16'($urandom_range(65535)));
			if ($urandom_range(7) == 0)
				write_reg(REG_SPARE, 16'($urandom_range(65535)));
			seg = $urandom_range(40, 120);
			repeat (seg) begin
				send_byte(8'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	// Sink holds off for a long stretch while bytes keep coming: the block
	// fills and has to hold s_tready low.
	task automatic test_output_hold();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		write_reg(fdr_pkg::REG_FRAME_LEN, 16'd7);
		hold_cycles = 300;
		repeat (150) send_byte(8'($urandom_range(255)));
	endtask

	// Frame length zero: the longest frame, so no beat here is flagged.
	task automatic test_full_length_frame();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		write_reg(fdr_pkg::REG_SKIP_BITS, 16'd8);
		write_reg(fdr_pkg::REG_SEED, 16'($urandom_range(1, 32767)));
		write_reg(fdr_pkg::REG_FRAME_LEN, 16'h0000);
		repeat (100) send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		seed_reg = fdr_pkg::SEED_RST;
		skip_reg = fdr_pkg::SKIP_RST;
		flen_reg = fdr_pkg::FRAME_LEN_RST;
		rebuild_start_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_seed_zero();
		test_register_fields();
		test_short_frames();
		test_random_traffic(0, 0, 400);
		test_random_traffic(71, 0, 400);
		test_random_traffic(0, 71, 400);
		test_random_traffic(22, 22, 400);
		test_output_hold();
		test_full_length_frame();

		wait_drained();
		// spare edges after draining catch any stray beat
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog: far beyond the slowest legal run (rebuild pauses included)
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: lfsr_frame_derandomizer_top.f
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_skip.sv
hw/rtl/lfsr_frame_derandomizer_top.sv
bench/tb_lfsr_frame_derandomizer_top.sv
